FILE: hw/rtl/edbpm_pkg.sv
// ----------------------------------------------------------------------------
// edbpm_pkg
// Types, field constants and the microprogram of the base point multiplier.
// ----------------------------------------------------------------------------
package edbpm_pkg;

  localparam int WORD_W    = 64;
  localparam int FE_W      = 256;
  localparam int RAM_DEPTH = 128;
  localparam int ADDR_W    = 7;
  localparam int WIDE_W    = 263;

  typedef struct packed {
    logic [63:0] scalar_word;
    logic [1:0]  word_index;
  } scalar_item_t;

  typedef struct packed {
    logic [63:0] encoded_word;
    logic [1:0]  out_index;
    logic        last_word;
  } point_item_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_FRZ = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] dst;
    logic [4:0] a;
    logic [4:0] b;
  } instr_t;

  // element numbers, four memory words each
  localparam logic [4:0] E_SCALAR = 5'd0;
  localparam logic [4:0] E_ONE    = 5'd1;
  localparam logic [4:0] E_ZERO   = 5'd2;
  localparam logic [4:0] E_D2     = 5'd3;
  localparam logic [4:0] E_BX     = 5'd4;
  localparam logic [4:0] E_BY     = 5'd5;
  localparam logic [4:0] E_P      = 5'd8;
  localparam logic [4:0] E_Q      = 5'd12;
  localparam logic [4:0] E_TA     = 5'd16;
  localparam logic [4:0] E_TB     = 5'd17;
  localparam logic [4:0] E_TC     = 5'd18;
  localparam logic [4:0] E_TD     = 5'd19;
  localparam logic [4:0] E_TT     = 5'd20;
  localparam logic [4:0] E_TE     = 5'd21;
  localparam logic [4:0] E_TF     = 5'd22;
  localparam logic [4:0] E_TG     = 5'd23;
  localparam logic [4:0] E_TH     = 5'd24;
  localparam logic [4:0] E_INV    = 5'd25;
  localparam logic [4:0] E_XA     = 5'd26;
  localparam logic [4:0] E_YA     = 5'd27;

  // program counter landmarks
  localparam logic [5:0] PC_INIT_END = 6'd7;
  localparam logic [5:0] PC_LADDER   = 6'd8;
  localparam logic [5:0] PC_DBL      = 6'd26;
  localparam logic [5:0] PC_LAD_END  = 6'd43;
  localparam logic [5:0] PC_INV      = 6'd44;
  localparam logic [5:0] PC_SQR      = 6'd45;
  localparam logic [5:0] PC_MULZ     = 6'd46;
  localparam logic [5:0] PC_AFF      = 6'd47;
  localparam logic [5:0] PC_END      = 6'd50;

  localparam logic [7:0] INV_TOP = 8'd253;

  localparam logic [255:0] K_P =
    256'h7fff_ffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff_ffed;
  localparam logic [255:0] K_D2 =
    256'h2406_d9dc_56df_fce7_198e_80f2_eef3_d130_00e0_149a_8283_b156_ebd6_9b94_26b2_f159;
  localparam logic [255:0] K_BX =
    256'h2169_36d3_cd6e_53fe_c0a4_e231_fdd6_dc5c_692c_c760_9525_a7b2_c956_2d60_8f25_d51a;
  localparam logic [255:0] K_BY =
    256'h6666_6666_6666_6666_6666_6666_6666_6666_6666_6666_6666_6666_6666_6666_6666_6658;
  localparam logic [WIDE_W-1:0] K_4P = {5'd0, K_P, 2'd0};

  function automatic logic is_const(input logic [4:0] e);
    return (e[4:3] == 2'b00) && (e != E_SCALAR);
  endfunction

  function automatic logic [255:0] const_val(input logic [4:0] e);
    logic [255:0] v;
    case (e)
      E_ONE:   v = 256'd1;
      E_D2:    v = K_D2;
      E_BX:    v = K_BX;
      E_BY:    v = K_BY;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic instr_t mk(input op_t o, input logic [4:0] d, input logic [4:0] a,
                                input logic [4:0] b);
    instr_t r;
    r.op = o;
    r.dst = d;
    r.a = a;
    r.b = b;
    return r;
  endfunction

  // unified point addition f = f + g
  function automatic instr_t add_step(input logic [4:0] s, input logic [4:0] f,
                                      input logic [4:0] g);
    instr_t r;
    case (s)
      5'd0:    r = mk(OP_SUB, E_TA, f + 5'd1, f);
      5'd1:    r = mk(OP_SUB, E_TT, g + 5'd1, g);
      5'd2:    r = mk(OP_MUL, E_TA, E_TA, E_TT);
      5'd3:    r = mk(OP_ADD, E_TB, f, f + 5'd1);
      5'd4:    r = mk(OP_ADD, E_TT, g, g + 5'd1);
      5'd5:    r = mk(OP_MUL, E_TB, E_TB, E_TT);
      5'd6:    r = mk(OP_MUL, E_TC, f + 5'd3, g + 5'd3);
      5'd7:    r = mk(OP_MUL, E_TC, E_TC, E_D2);
      5'd8:    r = mk(OP_MUL, E_TD, f + 5'd2, g + 5'd2);
      5'd9:    r = mk(OP_ADD, E_TD, E_TD, E_TD);
      5'd10:   r = mk(OP_SUB, E_TE, E_TB, E_TA);
      5'd11:   r = mk(OP_SUB, E_TF, E_TD, E_TC);
      5'd12:   r = mk(OP_ADD, E_TG, E_TD, E_TC);
      5'd13:   r = mk(OP_ADD, E_TH, E_TB, E_TA);
      5'd14:   r = mk(OP_MUL, f, E_TE, E_TF);
      5'd15:   r = mk(OP_MUL, f + 5'd1, E_TH, E_TG);
      5'd16:   r = mk(OP_MUL, f + 5'd2, E_TG, E_TF);
      default: r = mk(OP_MUL, f + 5'd3, E_TE, E_TH);
    endcase
    return r;
  endfunction

  function automatic instr_t prog_rom(input logic [5:0] pc);
    instr_t r;
    if (pc >= PC_LADDER && pc < PC_DBL) begin
      r = add_step(5'(pc - PC_LADDER), E_Q, E_P);
    end else if (pc >= PC_DBL && pc <= PC_LAD_END) begin
      r = add_step(5'(pc - PC_DBL), E_P, E_P);
    end else begin
      case (pc)
        6'd0:    r = mk(OP_ADD, E_P,        E_ZERO, E_ZERO);
        6'd1:    r = mk(OP_ADD, E_P + 5'd1, E_ONE,  E_ZERO);
        6'd2:    r = mk(OP_ADD, E_P + 5'd2, E_ONE,  E_ZERO);
        6'd3:    r = mk(OP_ADD, E_P + 5'd3, E_ZERO, E_ZERO);
        6'd4:    r = mk(OP_ADD, E_Q,        E_BX,   E_ZERO);
        6'd5:    r = mk(OP_ADD, E_Q + 5'd1, E_BY,   E_ZERO);
        6'd6:    r = mk(OP_ADD, E_Q + 5'd2, E_ONE,  E_ZERO);
        6'd7:    r = mk(OP_MUL, E_Q + 5'd3, E_BX,   E_BY);
        6'd44:   r = mk(OP_ADD, E_INV, E_P + 5'd2, E_ZERO);
        6'd45:   r = mk(OP_MUL, E_INV, E_INV, E_INV);
        6'd46:   r = mk(OP_MUL, E_INV, E_INV, E_P + 5'd2);
        6'd47:   r = mk(OP_MUL, E_XA, E_P, E_INV);
        6'd48:   r = mk(OP_MUL, E_YA, E_P + 5'd1, E_INV);
        6'd49:   r = mk(OP_FRZ, E_XA, E_XA, E_ZERO);
        default: r = mk(OP_FRZ, E_YA, E_YA, E_ZERO);
      endcase
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/edbpm_ram.sv
// ----------------------------------------------------------------------------
// edbpm_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module edbpm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/ed25519_base_point_multiply.sv
// ----------------------------------------------------------------------------
// ed25519_base_point_multiply
// Multiplies the Ed25519 base point by a 256-bit scalar and emits the packed
// point as four 64-bit words.
// ----------------------------------------------------------------------------
// Scalar words 0 to 2 are stored as they arrive; word 3 is stored and starts
// the multiplication. All field elements live in one 128 x 64 RAM and pass
// through a single field unit that loads two operands over the 64-bit port,
// adds, subtracts, reduces or multiplies them and writes the result back. A
// field multiplication uses one 32 x 32 multiplier that forms 64 partial
// products. The ladder needs 36 field operations per scalar bit and the
// inversion 506 multiplications; the block accepts no item until the fourth
// encoded word is taken.
module ed25519_base_point_multiply
  import edbpm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         scalar_valid,
  output logic         scalar_ready,
  input  scalar_item_t scalar_item,
  output logic         point_valid,
  input  logic         point_ready,
  output point_item_t  point_item
);

  typedef enum logic [19:0] {
    S_IDLE    = 20'h00001,
    S_BIT_RD  = 20'h00002,
    S_BIT_CAP = 20'h00004,
    S_LD_A    = 20'h00008,
    S_LD_B    = 20'h00010,
    S_EXEC    = 20'h00020,
    S_MUL_RUN = 20'h00040,
    S_MUL_D1  = 20'h00080,
    S_MUL_D2  = 20'h00100,
    S_RED     = 20'h00200,
    S_FOLD1   = 20'h00400,
    S_FOLD2   = 20'h00800,
    S_FRZ1    = 20'h01000,
    S_FRZ2    = 20'h02000,
    S_WB      = 20'h04000,
    S_NEXT    = 20'h08000,
    S_OUT_PR  = 20'h10000,
    S_OUT_PC  = 20'h20000,
    S_OUT_RD  = 20'h40000,
    S_OUT_SND = 20'h80000
  } state_t;

  state_t              state;
  logic [5:0]          pc;
  logic [7:0]          bit_counter;
  logic [7:0]          exp_idx;
  logic                swap;
  logic [2:0]          ld_cnt;
  logic [1:0]          wb_cnt;
  logic [1:0]          ok;
  logic                parity;
  logic [FE_W-1:0]     opa;
  logic [FE_W-1:0]     opb;
  logic [WIDE_W-1:0]   acc_w;
  logic [511:0]        pw;
  logic [63:0]         prod;
  logic                pv;
  logic                pend;
  logic [3:0]          pk;
  logic [71:0]         macc;
  logic [2:0]          mi;
  logic [3:0]          mkc;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  instr_t              ins;
  logic [4:0]          a_phys;
  logic [4:0]          b_phys;
  logic [4:0]          dst_phys;
  logic [4:0]          ld_elem;
  logic                ld_const;
  logic [2:0]          i_hi;
  logic [2:0]          mj;
  logic [71:0]         msum;
  logic                in_acc;
  logic [256:0]        frz_diff;

  function automatic logic [4:0] remap(input logic [4:0] e, input logic s);
    return (e[4:3] == 2'b01 && s) ? (e ^ 5'b00100) : e;
  endfunction

  assign ins      = prog_rom(pc);
  assign a_phys   = remap(ins.a, swap);
  assign b_phys   = remap(ins.b, swap);
  assign dst_phys = remap(ins.dst, swap);
  assign ld_elem  = (state == S_LD_A) ? a_phys : b_phys;
  assign ld_const = is_const(ld_elem);

  assign scalar_ready = (state == S_IDLE);
  assign in_acc       = scalar_valid && scalar_ready;
  assign point_valid  = (state == S_OUT_SND);

  assign i_hi     = (mkc < 4'd7) ? mkc[2:0] : 3'd7;
  assign mj       = 3'(mkc - {1'b0, mi});
  assign msum     = macc + {8'd0, prod};
  assign frz_diff = {1'b0, acc_w[255:0]} - {1'b0, K_P};

  always_comb begin
    ram_we    = in_acc || (state == S_WB);
    ram_waddr = in_acc ? {E_SCALAR, scalar_item.word_index} : {dst_phys, wb_cnt};
    ram_wdata = in_acc ? scalar_item.scalar_word : acc_w[{wb_cnt, 6'd0} +: 64];
    case (state)
      S_BIT_RD:  ram_raddr = {E_SCALAR, bit_counter[7:6]};
      S_LD_A:    ram_raddr = {ld_elem, ld_cnt[1:0]};
      S_LD_B:    ram_raddr = {ld_elem, ld_cnt[1:0]};
      S_OUT_PR:  ram_raddr = {E_XA, 2'd0};
      S_OUT_RD:  ram_raddr = {E_YA, ok};
      S_OUT_SND: ram_raddr = {E_YA, ok};
      default:   ram_raddr = '0;
    endcase
  end

  edbpm_ram #(
    .WIDTH(WORD_W),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // multiplier pipeline: product register then column accumulator
  always_ff @(posedge clk) begin
    prod <= opa[{mi, 5'd0} +: 32] * opb[{mj, 5'd0} +: 32];
    pend <= (mi == i_hi);
    pk   <= mkc;
    if (state == S_EXEC) begin
      macc <= '0;
    end else if (pv) begin
      if (pend) begin
        pw[{pk, 5'd0} +: 32] <= msum[31:0];
        macc <= {32'd0, msum[71:32]};
      end else begin
        macc <= msum;
      end
    end else if (state == S_MUL_D2) begin
      pw[511:480] <= macc[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pc          <= '0;
      bit_counter <= '0;
      exp_idx     <= '0;
      swap        <= 1'b0;
      ld_cnt      <= '0;
      wb_cnt      <= '0;
      ok          <= '0;
      pv          <= 1'b0;
      mi          <= '0;
      mkc         <= '0;
    end else begin
      pv <= (state == S_MUL_RUN);
      case (state)
        S_IDLE: begin
          if (in_acc && scalar_item.word_index == 2'd3) begin
            pc     <= '0;
            swap   <= 1'b0;
            ld_cnt <= '0;
            state  <= S_LD_A;
          end
        end
        S_BIT_RD: state <= S_BIT_CAP;
        S_BIT_CAP: begin
          swap   <= ram_rdata[bit_counter[5:0]];
          ld_cnt <= '0;
          state  <= S_LD_A;
        end
        S_LD_A: begin
          if (ld_cnt != 3'd0 && !ld_const) begin
            opa[{2'(ld_cnt - 3'd1), 6'd0} +: 64] <= ram_rdata;
          end
          if (ld_cnt == 3'd4) begin
            if (ld_const) begin
              opa <= const_val(ld_elem);
            end
            ld_cnt <= '0;
            state  <= S_LD_B;
          end else begin
            ld_cnt <= ld_cnt + 3'd1;
          end
        end
        S_LD_B: begin
          if (ld_cnt != 3'd0 && !ld_const) begin
            opb[{2'(ld_cnt - 3'd1), 6'd0} +: 64] <= ram_rdata;
          end
          if (ld_cnt == 3'd4) begin
            if (ld_const) begin
              opb <= const_val(ld_elem);
            end
            state <= S_EXEC;
          end else begin
            ld_cnt <= ld_cnt + 3'd1;
          end
        end
        S_EXEC: begin
          case (ins.op)
            OP_ADD: begin
              acc_w <= {7'd0, opa} + {7'd0, opb};
              state <= S_FOLD1;
            end
            OP_SUB: begin
              acc_w <= {7'd0, opa} + K_4P - {7'd0, opb};
              state <= S_FOLD1;
            end
            OP_MUL: begin
              mi    <= '0;
              mkc   <= '0;
              state <= S_MUL_RUN;
            end
            default: begin
              acc_w <= {7'd0, opa};
              state <= S_FRZ1;
            end
          endcase
        end
        S_MUL_RUN: begin
          if (mi == i_hi) begin
            if (mkc == 4'd14) begin
              state <= S_MUL_D1;
            end else begin
              mkc <= mkc + 4'd1;
              mi  <= (mkc >= 4'd7) ? 3'(mkc - 4'd6) : 3'd0;
            end
          end else begin
            mi <= mi + 3'd1;
          end
        end
        S_MUL_D1: state <= S_MUL_D2;
        S_MUL_D2: state <= S_RED;
        S_RED: begin
          acc_w <= {7'd0, pw[255:0]} + {2'd0, pw[511:256], 5'd0}
                   + {5'd0, pw[511:256], 2'd0} + {6'd0, pw[511:256], 1'b0};
          state <= S_FOLD1;
        end
        S_FOLD1: begin
          acc_w <= {7'd0, acc_w[255:0]}
                   + WIDE_W'({1'b0, acc_w[262:256], 5'd0} + {3'd0, acc_w[262:256], 2'd0}
                             + {4'd0, acc_w[262:256], 1'b0});
          state <= S_FOLD2;
        end
        S_FOLD2: begin
          acc_w <= {7'd0, acc_w[255:0] + (acc_w[256] ? 256'd38 : 256'd0)};
          wb_cnt <= '0;
          state  <= S_WB;
        end
        S_FRZ1: begin
          if (!frz_diff[256]) begin
            acc_w <= {7'd0, frz_diff[255:0]};
          end
          state <= S_FRZ2;
        end
        S_FRZ2: begin
          if (!frz_diff[256]) begin
            acc_w <= {7'd0, frz_diff[255:0]};
          end
          wb_cnt <= '0;
          state  <= S_WB;
        end
        S_WB: begin
          wb_cnt <= wb_cnt + 2'd1;
          if (wb_cnt == 2'd3) begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          ld_cnt <= '0;
          state  <= S_LD_A;
          if (pc == PC_INIT_END) begin
            bit_counter <= 8'd255;
            pc          <= PC_LADDER;
            state       <= S_BIT_RD;
          end else if (pc == PC_LAD_END) begin
            if (bit_counter == 8'd0) begin
              swap    <= 1'b0;
              exp_idx <= INV_TOP;
              pc      <= PC_INV;
            end else begin
              bit_counter <= bit_counter - 8'd1;
              pc          <= PC_LADDER;
              state       <= S_BIT_RD;
            end
          end else if (pc == PC_SQR) begin
            if (exp_idx == 8'd2 || exp_idx == 8'd4) begin
              exp_idx <= exp_idx - 8'd1;
            end else begin
              pc <= PC_MULZ;
            end
          end else if (pc == PC_MULZ) begin
            if (exp_idx == 8'd0) begin
              pc <= PC_AFF;
            end else begin
              exp_idx <= exp_idx - 8'd1;
              pc      <= PC_SQR;
            end
          end else if (pc == PC_END) begin
            state <= S_OUT_PR;
          end else begin
            pc <= pc + 6'd1;
          end
        end
        S_OUT_PR: state <= S_OUT_PC;
        S_OUT_PC: begin
          parity <= ram_rdata[0];
          ok     <= '0;
          state  <= S_OUT_RD;
        end
        S_OUT_RD: state <= S_OUT_SND;
        S_OUT_SND: begin
          if (point_ready) begin
            ok    <= ok + 2'd1;
            state <= (ok == 2'd3) ? S_IDLE : S_OUT_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // read data stays put while the word waits, x parity goes on top of the last word
  assign point_item.encoded_word = {(ok == 2'd3) ? parity : ram_rdata[63], ram_rdata[62:0]};
  assign point_item.out_index    = ok;
  assign point_item.last_word    = (ok == 2'd3);

  assert property (@(posedge clk) disable iff (rst) scalar_ready |-> !point_valid)
    else $error("input taken while a result is pending");
  assert property (@(posedge clk) disable iff (rst)
                   swap |-> (pc >= PC_LADDER && pc <= PC_LAD_END))
    else $error("point swap active outside the ladder");
  assert property (@(posedge clk) disable iff (rst)
                   (point_valid && point_ready && point_item.last_word) |=> scalar_ready)
    else $error("block not idle after the last word");
  assert property (@(posedge clk) disable iff (rst) (state == S_WB) |-> (dst_phys != E_SCALAR))
    else $error("write-back into the scalar words");

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the Ed25519 base point multiplier against a predictor with modular
// integer arithmetic. Scalar words are sent, word 3 starts the multiplication,
// and each encoded word is compared with the predicted result words in order.
// ----------------------------------------------------------------------------
module tb
  import edbpm_pkg::*;
();

  typedef logic [255:0] fe_t;
  typedef struct {
    fe_t x;
    fe_t y;
    fe_t z;
    fe_t t;
  } ext_point_t;

  localparam int unsigned CYCLE_LIMIT = 250000000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned LONG_HOLD = 3000;

  logic         clk;
  logic         rst;
  logic         scalar_valid;
  logic         scalar_ready;
  scalar_item_t scalar_item;
  logic         point_valid;
  logic         point_ready;
  point_item_t  point_item;

  logic [63:0]  scalar_words [4];
  point_item_t  expected_words [$];
  int unsigned  mismatches;
  int unsigned  cycles;
  int unsigned  hold_left;
  logic         long_hold_req;

  ed25519_base_point_multiply i_dut (
    .clk          (clk),
    .rst          (rst),
    .scalar_valid (scalar_valid),
    .scalar_ready (scalar_ready),
    .scalar_item  (scalar_item),
    .point_valid  (point_valid),
    .point_ready  (point_ready),
    .point_item   (point_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic fe_t field_reduce(input logic [519:0] v);
    while (v[519:255] != 0) v = v[254:0] + v[519:255] * 19;
    if (v >= K_P) v = v - K_P;
    return v[255:0];
  endfunction

  function automatic fe_t field_mul(input fe_t a, input fe_t b);
    logic [519:0] v;
    v = a;
    v = v * b;
    return field_reduce(v);
  endfunction

  function automatic fe_t field_add(input fe_t a, input fe_t b);
    logic [519:0] v;
    v = a;
    v = v + b;
    return field_reduce(v);
  endfunction

  function automatic fe_t field_sub(input fe_t a, input fe_t b);
    logic [519:0] v;
    v = a;
    v = v + K_P - b;
    return field_reduce(v);
  endfunction

  function automatic fe_t field_inverse(input fe_t a);
    fe_t e;
    fe_t r;
    e = K_P - 256'd2;
    r = 256'd1;
    for (int i = 255; i >= 0; i--) begin
      r = field_mul(r, r);
      if (e[i]) r = field_mul(r, a);
    end
    return r;
  endfunction

  function automatic ext_point_t point_sum(input ext_point_t p, input ext_point_t q);
    fe_t a, b, c, d, e, f, g, h;
    ext_point_t r;
    a = field_mul(field_sub(p.y, p.x), field_sub(q.y, q.x));
    b = field_mul(field_add(p.x, p.y), field_add(q.x, q.y));
    c = field_mul(field_mul(p.t, q.t), K_D2);
    d = field_mul(p.z, q.z);
    d = field_add(d, d);
    e = field_sub(b, a);
    f = field_sub(d, c);
    g = field_add(d, c);
    h = field_add(b, a);
    r.x = field_mul(e, f);
    r.y = field_mul(h, g);
    r.z = field_mul(g, f);
    r.t = field_mul(e, h);
    return r;
  endfunction

  // ladder over all 256 scalar bits, then affine y with x parity on top
  task automatic predict_encoding();
    logic [255:0] k;
    ext_point_t   p, q, s;
    fe_t          zi, ax, ay;
    point_item_t  w;
    k = {scalar_words[3], scalar_words[2], scalar_words[1], scalar_words[0]};
    p.x = '0;
    p.y = 256'd1;
    p.z = 256'd1;
    p.t = '0;
    q.x = K_BX;
    q.y = K_BY;
    q.z = 256'd1;
    q.t = field_mul(K_BX, K_BY);
    for (int i = 255; i >= 0; i--) begin
      s = point_sum(p, q);
      if (k[i]) begin
        q = point_sum(q, q);
        p = s;
      end else begin
        q = s;
        p = point_sum(p, p);
      end
    end
    zi = field_inverse(p.z);
    ax = field_mul(p.x, zi);
    ay = field_mul(p.y, zi);
    ay[255] = ax[0];
    for (int j = 0; j < 4; j++) begin
      w.encoded_word = ay[64*j +: 64];
      w.out_index = 2'(j);
      w.last_word = (j == 3);
      expected_words.push_back(w);
    end
  endtask

  task automatic send_word(input logic [63:0] value, input logic [1:0] idx);
    int unsigned gap;
    scalar_item <= '{scalar_word: value, word_index: idx};
    scalar_valid <= 1'b1;
    do @(posedge clk); while (!scalar_ready);
    scalar_words[idx] = value;
    if (idx == 2'd3) predict_encoding();
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if (gap > 0) begin
      scalar_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    scalar_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic send_scalar(input logic [255:0] k);
    for (int i = 0; i < 4; i++) send_word(k[64*i +: 64], 2'(i));
  endtask

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic test_zero_scalar();
    send_scalar('0);
  endtask

  task automatic test_unit_scalar();
    send_scalar(256'd1);
  endtask

  task automatic test_all_ones();
    send_scalar('1);
  endtask

  task automatic test_top_bit_only();
    send_scalar({1'b1, 255'd0});
  endtask

  task automatic test_word3_reuse();
    send_word({$urandom, $urandom}, 2'd3);
  endtask

  task automatic test_output_backpressure();
    long_hold_req = 1'b1;
    send_word({$urandom, $urandom}, 2'd3);
    send_word({$urandom, $urandom}, 2'd0);
    send_word({$urandom, $urandom}, 2'd1);
  endtask

  task automatic test_drain_pause();
    wait_drained();
    send_word({$urandom, $urandom}, 2'd2);
    send_word({$urandom, $urandom}, 2'd3);
  endtask

  task automatic test_random_words();
    for (int n = 0; n < 80; n++) begin
      if ($urandom_range(0, 11) == 0) send_word(pick_word(), 2'd3);
      else send_word(pick_word(), 2'($urandom_range(0, 2)));
    end
  endtask

  // result checker and receiver stalls
  initial begin
    point_item_t e;
    point_ready <= 1'b0;
    hold_left = 0;
    long_hold_req = 1'b0;
    mismatches = 0;
    forever begin
      @(posedge clk);
      if (!rst && point_valid && point_ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: word %h index %0d last %0b",
                     point_item.encoded_word, point_item.out_index, point_item.last_word);
        end else begin
          e = expected_words.pop_front();
          if (point_item !== e) begin
            mismatches++;
            if (mismatches <= 10)
              $display("item mismatch: expected %h/%0d/%0b actual %h/%0d/%0b",
                       e.encoded_word, e.out_index, e.last_word,
                       point_item.encoded_word, point_item.out_index, point_item.last_word);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        point_ready <= 1'b0;
      end else if (long_hold_req && point_valid) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
        point_ready <= 1'b0;
      end else if ($urandom_range(0, 39) == 0) begin
        hold_left = $urandom_range(5, 80);
        point_ready <= 1'b0;
      end else begin
        point_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    scalar_valid <= 1'b0;
    scalar_item <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_zero_scalar();
    test_unit_scalar();
    test_all_ones();
    test_top_bit_only();
    test_word3_reuse();
    test_output_backpressure();
    test_drain_pause();
    test_random_words();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
